// ===== src/tbsq_pkg.sv =====
package tbsq_pkg;

   localparam int unsigned PosWidth      = 16;
   localparam int unsigned CfgWidth      = 16;
   localparam int unsigned PercentWidth  = 7;
   localparam int unsigned ScaleWidth    = 7;
   localparam int unsigned DividendWidth = PosWidth + ScaleWidth;
   localparam int unsigned CountWidth    = $clog2(DividendWidth);
   localparam int unsigned CsrIndexWidth = 4;

   localparam logic [ScaleWidth-1:0]   PercentFull     = 7'd100;
   localparam logic [PosWidth-1:0]     NoTouchMark     = 16'hFFFF;
   localparam logic [CfgWidth-1:0]     ResetLongPress  = 16'd2000;
   localparam logic [CfgWidth-1:0]     ResetResolution = 16'd100;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LONG_PRESS_TICKS  = 4'd0,
      CSR_SLIDER_RESOLUTION = 4'd1
   } csr_index_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_TICK   = 1'b1
   } kind_type;

   typedef struct packed {
      logic                kind;
      logic                btn0_active;
      logic                btn1_active;
      logic                slider_touched;
      logic [PosWidth-1:0] touch_pos;
   } req_type;

   typedef struct packed {
      logic                    btn0_press;
      logic                    btn1_long_press;
      logic                    volume_valid;
      logic [PercentWidth-1:0] volume_percent;
   } rsp_type;

endpackage

// ===== src/tbsq_div.sv =====
module tbsq_div
   import tbsq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DividendWidth-1:0] dividend,
   input  logic [CfgWidth-1:0]      divisor,
   output logic                     done,
   output logic [DividendWidth-1:0] quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CountWidth-1:0]    cnt_ff, cnt_in;
   logic [CfgWidth-1:0]      rem_ff, rem_in;
   logic [DividendWidth-1:0] quo_ff, quo_in;
   logic [CfgWidth-1:0]      dvs_ff, dvs_in;
   logic [CfgWidth:0]        trial;
   logic [CfgWidth:0]        diff;
   logic                     fits;

   // one restoring step per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[DividendWidth-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CfgWidth-1:0] : trial[CfgWidth-1:0];
         quo_in = {quo_ff[DividendWidth-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CountWidth'(DividendWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/touch_button_slider_qualifier.sv =====
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_type (kind, buttons, slider)
// rsp_      out        rsp_valid/rsp_stall  rsp_type (press, long press, volume)
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// an item goes from idle to done, via the divider state when a new slider percent is
// computed; it goes through a 23-step restoring divider, one quotient bit a cycle
// reset is synchronous and restores the default thresholds and a released panel
// req_stall is high while an item is in work; a finished beat waits in the
// output register while the next item is taken

module touch_button_slider_qualifier
   import tbsq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [CfgWidth-1:0]      lpt_ff, lpt_in;
   logic [CfgWidth-1:0]      res_ff, res_in;
   logic                     last_btn0_ff, last_btn0_in;
   logic                     last_btn1_ff, last_btn1_in;
   logic                     armed_ff, armed_in;
   logic [CfgWidth-1:0]      count_ff, count_in;
   logic [PosWidth-1:0]      last_slider_ff, last_slider_in;
   logic                     press_ff, press_in;
   logic                     longp_ff, longp_in;
   logic                     vvalid_ff, vvalid_in;
   logic [PercentWidth-1:0]  pct_ff, pct_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     accept;
   logic                     csr_write;
   logic [DividendWidth-1:0] product;
   logic                     div_start;
   logic                     div_done;
   logic [DividendWidth-1:0] quotient;

   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_valid && csr_ready;
   assign product   = DividendWidth'(req_payload.touch_pos) * DividendWidth'(PercentFull);

   tbsq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (res_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      lpt_in = lpt_ff;
      res_in = res_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LONG_PRESS_TICKS:  lpt_in = csr_wdata;
            CSR_SLIDER_RESOLUTION: res_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      last_btn0_in   = last_btn0_ff;
      last_btn1_in   = last_btn1_ff;
      armed_in       = armed_ff;
      count_in       = count_ff;
      last_slider_in = last_slider_ff;
      press_in       = press_ff;
      longp_in       = longp_ff;
      vvalid_in      = vvalid_ff;
      pct_in         = pct_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      div_start      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               press_in  = 1'b0;
               vvalid_in = 1'b0;
               pct_in    = '0;
               if (req_payload.kind == KIND_SAMPLE) begin
                  press_in = req_payload.btn0_active && !last_btn0_ff;
                  if (req_payload.btn1_active && !last_btn1_ff) begin
                     armed_in = 1'b1;
                     count_in = '0;
                  end
                  if (!req_payload.btn1_active && last_btn1_ff) begin
                     armed_in = 1'b0;
                  end
                  if (req_payload.slider_touched &&
                      req_payload.touch_pos != last_slider_ff) begin
                     vvalid_in      = 1'b1;
                     last_slider_in = req_payload.touch_pos;
                  end else if (!req_payload.slider_touched) begin
                     last_slider_in = NoTouchMark;
                  end
                  last_btn0_in = req_payload.btn0_active;
                  last_btn1_in = req_payload.btn1_active;
               end else begin
                  if (armed_ff && count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               longp_in = armed_in && (count_in >= lpt_ff);
               if (longp_in) begin
                  armed_in = 1'b0;
               end
               if (vvalid_in && res_ff != '0) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               // saturate at full scale
               pct_in   = (quotient > DividendWidth'(PercentFull)) ?
                          PercentFull : quotient[PercentWidth-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.btn0_press      = press_ff;
               rsp_in.btn1_long_press = longp_ff;
               rsp_in.volume_valid    = vvalid_ff;
               rsp_in.volume_percent  = pct_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         lpt_ff         <= ResetLongPress;
         res_ff         <= ResetResolution;
         last_btn0_ff   <= 1'b0;
         last_btn1_ff   <= 1'b0;
         armed_ff       <= 1'b0;
         count_ff       <= '0;
         last_slider_ff <= NoTouchMark;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lpt_ff         <= lpt_in;
         res_ff         <= res_in;
         last_btn0_ff   <= last_btn0_in;
         last_btn1_ff   <= last_btn1_in;
         armed_ff       <= armed_in;
         count_ff       <= count_in;
         last_slider_ff <= last_slider_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      press_ff  <= press_in;
      longp_ff  <= longp_in;
      vvalid_ff <= vvalid_in;
      pct_ff    <= pct_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule
